FILE: sv/linear_attack_release_envelope_vca_assert.svh
// Assertion macros shared by the envelope/VCA modules.
// No dependencies; included by files that carry assertions.
`ifndef LINEAR_ATTACK_RELEASE_ENVELOPE_VCA_ASSERT_SVH
`define LINEAR_ATTACK_RELEASE_ENVELOPE_VCA_ASSERT_SVH

// Checked only while out of reset.
`define LAREV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define LAREV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: sv/larev_pkg.sv
// Shared types and constants for the linear AR envelope with VCA.
// No dependencies.
package larev_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 17;
    localparam int STEP_W    = 24;
    localparam int ENV_W     = 24;
    localparam int CNT_W     = 25;
    localparam int CFG_A_W   = 2;
    localparam int CFG_D_W   = 24;
    localparam int ENV_LO_W  = 12;
    localparam int P1_W      = SAMPLE_W + GAIN_W;        // sample * gain
    localparam int PP_W      = P1_W + ENV_LO_W + 1;      // partial product
    localparam int ACC_W     = P1_W + ENV_W;             // full product
    localparam int PROD_SHIFT = 39;

    localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(16384);
    localparam logic [STEP_W-1:0] ATTACK_RST    = STEP_W'(19022);
    localparam logic [STEP_W-1:0] RELEASE_RST   = STEP_W'(1902);
    localparam logic [STEP_W-1:0] REL_POINT_RST = STEP_W'(44100);
    localparam logic [ENV_W-1:0]  ENV_ONE       = ENV_W'(8388608);

    typedef enum logic [CFG_A_W-1:0] {
        CFG_GAIN      = 2'd0,
        CFG_ATTACK    = 2'd1,
        CFG_RELEASE   = 2'd2,
        CFG_REL_POINT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI
    } t_state;

    typedef struct packed {
        logic load;     // capture request, sample * gain
        logic mul_lo;   // low envelope partial product
        logic finish;   // high partial, output, state update
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

FILE: sv/larev_ctrl.sv
// Sequencer for one request at a time through the split multiply.
// Depends on larev_pkg and the assertion macro header.
`include "linear_attack_release_envelope_vca_assert.svh"

module larev_ctrl
    import larev_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `LAREV_ASSERT(a_load_to_lo, i_clk, i_rst_n, o_cmd.load |=> r_state == ST_MUL_LO, "load not followed by low partial")
    `LAREV_ASSERT(a_lo_to_hi, i_clk, i_rst_n, r_state == ST_MUL_LO |=> r_state == ST_MUL_HI, "low partial not followed by high partial")
    `LAREV_ASSERT(a_finish_idle, i_clk, i_rst_n, o_cmd.finish |=> s_axis_tready, "not ready after finish")

endmodule

FILE: sv/larev_datapath.sv
// Config registers, envelope state, split multiplier and output register.
// Depends on larev_pkg and the assertion macro header.
`include "linear_attack_release_envelope_vca_assert.svh"

module larev_datapath
    import larev_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_A_W-1:0]    i_cfg_addr,
    input  logic [CFG_D_W-1:0]    i_cfg_data,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_trigger,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SAMPLE_W-1:0]   o_result
);

    logic [GAIN_W-1:0]          r_gain;
    logic [STEP_W-1:0]          r_attack;
    logic [STEP_W-1:0]          r_release;
    logic [STEP_W-1:0]          r_rel_point;
    logic [ENV_W-1:0]           r_env;
    logic [ENV_W-1:0]           n_env;
    logic [CNT_W-1:0]           r_elapsed;
    logic                       r_held;
    logic signed [P1_W-1:0]     r_prod1;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_out;
    logic [SAMPLE_W-1:0]        n_out;

    logic signed [SAMPLE_W-1:0] w_s;
    logic signed [GAIN_W:0]     w_g;
    logic signed [P1_W:0]       w_p1;
    logic signed [PP_W-1:0]     w_plo;
    logic signed [PP_W-1:0]     w_phi;
    logic signed [ACC_W-1:0]    w_sum;
    logic [ACC_W-PROD_SHIFT-1:0] w_shr;
    logic                       w_releasing;
    logic [ENV_W:0]             w_up;
    logic                       w_start;

    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_result        = r_out;

    assign w_start = i_cmd.load && i_trigger;

    assign w_s   = $signed(i_sample);
    assign w_g   = $signed({1'b0, r_gain});
    assign w_p1  = (P1_W+1)'(w_s) * (P1_W+1)'(w_g);
    assign w_plo = PP_W'(r_prod1) * PP_W'($signed({1'b0, r_env[ENV_LO_W-1:0]}));
    assign w_phi = PP_W'(r_prod1) * PP_W'($signed({1'b0, r_env[ENV_W-1:ENV_LO_W]}));
    assign w_sum = r_acc + ($signed({{(ACC_W-PP_W){w_phi[PP_W-1]}}, w_phi}) <<< ENV_LO_W);
    assign w_shr = w_sum[ACC_W-1:PROD_SHIFT];

    // saturate the floored product to Q1.23
    always_comb begin
        n_out = w_shr[SAMPLE_W-1:0];
        if (w_shr[ACC_W-PROD_SHIFT-1:SAMPLE_W-1] != '0 &&
            w_shr[ACC_W-PROD_SHIFT-1:SAMPLE_W-1] != '1) begin
            n_out = w_shr[ACC_W-PROD_SHIFT-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                              : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    assign w_releasing = !r_held || (r_elapsed > {1'b0, r_rel_point});
    assign w_up        = {1'b0, r_env} + {1'b0, r_attack};

    always_comb begin
        if (w_releasing) begin
            n_env = (r_env > r_release) ? r_env - r_release : '0;
        end else begin
            n_env = (w_up > {1'b0, ENV_ONE}) ? ENV_ONE : w_up[ENV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RST;
            r_attack    <= ATTACK_RST;
            r_release   <= RELEASE_RST;
            r_rel_point <= REL_POINT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_GAIN:      r_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_ATTACK:    r_attack    <= i_cfg_data[STEP_W-1:0];
                CFG_RELEASE:   r_release   <= i_cfg_data[STEP_W-1:0];
                CFG_REL_POINT: r_rel_point <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env       <= '0;
            r_elapsed   <= '0;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_start) begin
                r_held    <= 1'b1;
                r_elapsed <= '0;
            end
            if (i_cmd.finish) begin
                r_env <= n_env;
                if (r_elapsed != '1) begin
                    r_elapsed <= r_elapsed + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod1 <= w_p1[P1_W-1:0];
        end
        if (i_cmd.mul_lo) begin
            r_acc <= {{(ACC_W-PP_W){w_plo[PP_W-1]}}, w_plo};
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    `LAREV_ASSERT(a_env_range, i_clk, i_rst_n, r_env <= ENV_ONE, "envelope above full scale")
    `LAREV_ASSERT(a_finish_slot, i_clk, i_rst_n, i_cmd.finish |-> o_stat.out_free, "overrun")
    `LAREV_ASSERT(a_trig, i_clk, i_rst_n, w_start |=> r_held && ~|r_elapsed, "no note start")

endmodule

FILE: sv/linear_attack_release_envelope_vca.sv
// Linear attack/release envelope generator with VCA, top level.
// Depends on larev_pkg, larev_ctrl and larev_datapath.
//
// Usage:
//   Input stream: s_axis_tdata carries the Q1.23 oscillator sample, s_axis_tuser
//   the key trigger. One request yields one output request on m_axis with the
//   scaled sample on both left and right halves of m_axis_tdata.
//   Config: write gain, attack step, release step and release point through
//   i_cfg_we/i_cfg_addr/i_cfg_data while no request is in flight.
//   Sequence: the request is captured and sample*gain registered in ST_IDLE,
//   then two partial products are formed against the 12-bit halves of the
//   envelope, the low one in ST_MUL_LO and the high one with the output in
//   ST_MUL_HI; no new request is taken until the current one finishes.
//   The output register holds the finished result while the next input is
//   taken; if the receiver stalls, the block holds its last multiply step
//   until the output register frees, and the input side waits meanwhile.
//   Reset: config registers return to their defaults, envelope, sample
//   counter and key state clear, and the output holds no result.
module linear_attack_release_envelope_vca
    import larev_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // [23:0] osc_sample
    input  logic                 s_axis_tuser,   // [0] key_trigger
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // [23:0] left_out, [47:24] right_out
    input  logic                 i_cfg_we,
    input  logic [CFG_A_W-1:0]   i_cfg_addr,
    input  logic [CFG_D_W-1:0]   i_cfg_data
);

    t_dp_cmd             w_cmd;
    t_dp_stat            w_stat;
    logic [SAMPLE_W-1:0] w_result;

    larev_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    larev_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_sample   (s_axis_tdata),
        .i_trigger  (s_axis_tuser),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (w_result)
    );

    assign m_axis_tdata = {w_result, w_result};

endmodule

FILE: dv/linear_attack_release_envelope_vca_test.sv
`timescale 1ns / 1ps
// Self-checking bench for linear_attack_release_envelope_vca: streams samples and key
// triggers under several register settings and checks every output against a local model.
// Depends on larev_pkg and the block's sources.
module linear_attack_release_envelope_vca_test;
    import larev_pkg::*;

    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 48;

    class envelope_scoreboard;
        logic [GAIN_W-1:0]   gain;
        logic [STEP_W-1:0]   atk_step;
        logic [STEP_W-1:0]   rel_step;
        logic [STEP_W-1:0]   rel_point;
        logic [ENV_W-1:0]    env_level;
        logic [CNT_W-1:0]    elapsed;
        logic                held;
        logic [SAMPLE_W-1:0] expected_vca[$];
        int                  mismatches;
        int                  results;

        function new();
            gain       = GAIN_RST;
            atk_step   = ATTACK_RST;
            rel_step   = RELEASE_RST;
            rel_point  = REL_POINT_RST;
            env_level  = '0;
            elapsed    = '0;
            held       = 1'b0;
            mismatches = 0;
            results    = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_D_W-1:0] val);
            case (idx)
                CFG_GAIN:      gain      = val[GAIN_W-1:0];
                CFG_ATTACK:    atk_step  = val;
                CFG_RELEASE:   rel_step  = val;
                CFG_REL_POINT: rel_point = val;
                default: ;
            endcase
        endfunction

        function void queue_expected(logic [SAMPLE_W-1:0] val);
            expected_vca = {expected_vca, val};
        endfunction

        // Output uses the envelope from before this sample's update.
        function void note_sample(logic [SAMPLE_W-1:0] smp, logic trig);
            logic signed [66:0] s_ext;
            logic signed [66:0] g_ext;
            logic signed [66:0] e_ext;
            logic signed [66:0] prod;
            logic [ENV_W:0]     up;
            logic               releasing;
            if (trig) begin
                held    = 1'b1;
                elapsed = '0;
            end
            s_ext = 67'($signed(smp));
            g_ext = {50'd0, gain};
            e_ext = {43'd0, env_level};
            prod  = (s_ext * g_ext * e_ext) >>> PROD_SHIFT;
            if (prod > 67'sd8388607)
                queue_expected(24'h7FFFFF);
            else if (prod < -67'sd8388608)
                queue_expected(24'h800000);
            else
                queue_expected(prod[SAMPLE_W-1:0]);

            releasing = !held || (elapsed > CNT_W'(rel_point));
            if (releasing) begin
                env_level = (env_level > rel_step) ? env_level - rel_step : '0;
            end else begin
                up = {1'b0, env_level} + {1'b0, atk_step};
                env_level = (up > {1'b0, ENV_ONE}) ? ENV_ONE : up[ENV_W-1:0];
            end
            if (elapsed != {CNT_W{1'b1}})
                elapsed = elapsed + 1'b1;
        endfunction

        function void check_result(logic [47:0] data);
            logic [SAMPLE_W-1:0] exp_v;
            results++;
            if (expected_vca.size() == 0) begin
                mismatches++;
                $display("%0t: output with no sample pending, left %h right %h",
                         $time, data[23:0], data[47:24]);
                return;
            end
            exp_v = expected_vca.pop_front();
            if (data[23:0] !== exp_v) begin
                mismatches++;
                $display("%0t: left_out mismatch, expected %h actual %h",
                         $time, exp_v, data[23:0]);
            end
            if (data[47:24] !== exp_v) begin
                mismatches++;
                $display("%0t: right_out mismatch, expected %h actual %h",
                         $time, exp_v, data[47:24]);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata = '0;   // [23:0] osc_sample
    logic                s_axis_tuser = 1'b0; // [0] key_trigger
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [47:0]         m_axis_tdata;        // [23:0] left_out, [47:24] right_out
    logic                i_cfg_we = 1'b0;
    t_cfg_idx            i_cfg_addr = CFG_GAIN;
    logic [CFG_D_W-1:0]  i_cfg_data = '0;

    envelope_scoreboard sb = new();
    bit tx_idle_ok = 1'b1;
    bit rx_idle_ok = 1'b1;
    int samples_sent = 0;
    int settings = 0;

    linear_attack_release_envelope_vca u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_sample(logic [23:0] smp, logic trig);
        int gap;
        @(negedge i_clk);
        if (tx_idle_ok && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = smp;
        s_axis_tuser  = trig;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_sample(smp, trig);
        samples_sent++;
    endtask

    // Sender holds off until every pending output has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_vca.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [CFG_D_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic program_regs(logic [23:0] g, logic [23:0] a, logic [23:0] r,
                                logic [23:0] p);
        write_cfg(CFG_GAIN, g);
        write_cfg(CFG_ATTACK, a);
        write_cfg(CFG_RELEASE, r);
        write_cfg(CFG_REL_POINT, p);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        settings++;
    endtask

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return 24'd65536;
            2:       return 24'h01FFFF;
            3:       return 24'd16384;
            4:       return 24'($urandom);
            default: return 24'($urandom_range(0, 131071));
        endcase
    endfunction

    function automatic logic [23:0] pick_step();
        case ($urandom_range(0, 7))
            0:       return 24'd0;
            1:       return 24'd1;
            2:       return 24'h800000;
            3:       return 24'hFFFFFF;
            4:       return 24'($urandom);
            default: return 24'($urandom_range(24'h020000, 24'h400000));
        endcase
    endfunction

    function automatic logic [23:0] pick_rel_point();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom);
            default: return 24'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'hFFFFFF;
            3:       return 24'h000001;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                m_axis_tready = 1'b0;
            end else if (rx_idle_ok && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(0, 11);
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    initial begin
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        int ph;
        int n;
        logic trig;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h000000, 1'b0);
        drain_results();

        // gain above unity, attack past full scale, zero release step
        program_regs(24'h01FFFF, 24'hFFFFFF, 24'd0, 24'd2);
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b0);
        send_sample(24'hFFFFFF, 1'b0);
        send_sample(24'h000001, 1'b0);
        send_sample(24'h400000, 1'b0);
        send_sample(24'hC00000, 1'b0);
        drain_results();

        // unity gain, zero attack, release past full scale
        program_regs(24'd65536, 24'd0, 24'hFFFFFF, 24'd0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b1);
        send_sample(24'h123456, 1'b0);
        send_sample(24'hFFFFFF, 1'b0);
        drain_results();

        // gain bits above the register width are dropped, gain becomes zero
        program_regs(24'hFE0000, 24'h800000, 24'd1, 24'hFFFFFF);
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h5A5A5A, 1'b0);
        send_sample(24'hA5A5A5, 1'b0);
        drain_results();

        program_regs(24'd1, 24'h800000, 24'h800000, 24'd1);
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b0);
        drain_results();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph >= RANDOM_PHASES - 2) begin
                tx_idle_ok = 1'b0;
                rx_idle_ok = 1'b0;
            end
            program_regs(pick_gain(), pick_step(), pick_step(), pick_rel_point());
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 0)
                    trig = ($urandom_range(0, 3) != 0);
                else
                    trig = ($urandom_range(0, 29) == 0);
                send_sample(pick_sample(), trig);
            end
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        $display("Covered %0d samples and %0d outputs over %0d register settings,",
                 samples_sent, sb.results, settings);
        $display("gains from zero to above unity, steps from zero to beyond full scale.");
        if (sb.mismatches == 0 && sb.expected_vca.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0t: %0d mismatches, %0d outputs missing",
                     $time, sb.mismatches, sb.expected_vca.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
